/* hdl/lvw_pkg.sv */
// Shared widths, codes, types and helpers for the 3D line voxel walker.
package lvw_pkg;

    localparam int COORD_BITS  = 16;
    localparam int LIMIT_BITS  = 15;
    localparam int MAG_BITS    = COORD_BITS;
    localparam int TWICE_BITS  = COORD_BITS + 1;
    localparam int ERR_BITS    = COORD_BITS + 4;
    localparam int CMP_BITS    = (COORD_BITS > LIMIT_BITS) ? COORD_BITS : LIMIT_BITS;
    localparam int CFG_IDX_BITS = 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LIMIT_BITS-1:0] LIMIT_X_RESET = LIMIT_BITS'(680);
    localparam logic [LIMIT_BITS-1:0] LIMIT_Y_RESET = LIMIT_BITS'(170);
    localparam logic [LIMIT_BITS-1:0] LIMIT_Z_RESET = LIMIT_BITS'(170);

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LIMIT_X = 2'd0,
        CFG_LIMIT_Y = 2'd1,
        CFG_LIMIT_Z = 2'd2
    } cfg_index_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [MAG_BITS-1:0]          mag_t;
    typedef logic [LIMIT_BITS-1:0]        limit_t;

    // One decoded request as it travels from the front end to the walker.
    typedef struct packed {
        opcode_t op;
        coord_t  sx;
        coord_t  sy;
        coord_t  sz;
        mag_t    mx;
        mag_t    my;
        mag_t    mz;
        logic    neg_x;
        logic    neg_y;
        logic    neg_z;
    } cmd_t;

    typedef struct packed {
        logic   valid_res;
        coord_t x;
        coord_t y;
        coord_t z;
        logic   in_box;
        logic   last;
    } res_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Magnitude of a difference of two coordinates; it always fits MAG_BITS.
    function automatic mag_t mag_of(input logic signed [COORD_BITS:0] d);
        logic [COORD_BITS:0] n;
        n = d[COORD_BITS] ? (~d + 1'b1) : d;
        return n[COORD_BITS-1:0];
    endfunction

    // Magnitude of a coordinate, read as unsigned; the most negative value maps correctly.
    function automatic logic [COORD_BITS-1:0] abs_coord(input coord_t c);
        return c[COORD_BITS-1] ? (~c + 1'b1) : c;
    endfunction

endpackage

/* hdl/lvw_front.sv */
// Front end: classifies a request and works out the per-axis deltas and step signs.
module lvw_front (
    input  logic                             opcode,
    input  logic signed [lvw_pkg::COORD_BITS-1:0] start_x,
    input  logic signed [lvw_pkg::COORD_BITS-1:0] start_y,
    input  logic signed [lvw_pkg::COORD_BITS-1:0] start_z,
    input  logic signed [lvw_pkg::COORD_BITS-1:0] end_x,
    input  logic signed [lvw_pkg::COORD_BITS-1:0] end_y,
    input  logic signed [lvw_pkg::COORD_BITS-1:0] end_z,
    output lvw_pkg::cmd_t                    cmd
);
    import lvw_pkg::*;

    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic signed [COORD_BITS:0] dz;

    assign dx = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
    assign dy = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
    assign dz = {end_z[COORD_BITS-1], end_z} - {start_z[COORD_BITS-1], start_z};

    always_comb
    begin
        cmd.op    = opcode_t'(opcode);
        cmd.sx    = start_x;
        cmd.sy    = start_y;
        cmd.sz    = start_z;
        cmd.mx    = mag_of(dx);
        cmd.my    = mag_of(dy);
        cmd.mz    = mag_of(dz);
        cmd.neg_x = dx[COORD_BITS];
        cmd.neg_y = dy[COORD_BITS];
        cmd.neg_z = dz[COORD_BITS];
    end

endmodule

/* hdl/lvw_queue.sv */
// Short register queue that decouples the front end from the walker.
module lvw_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lvw_pkg::cmd_t    wr_entry,
    input  logic             pop,
    output lvw_pkg::cmd_t    head,
    output lvw_pkg::q_stat_t stat
);
    import lvw_pkg::*;

    cmd_t                 mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;

    assign wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

/* hdl/lvw_back.sv */
// Walker: holds the line state, applies loads and steps one voxel per request.
module lvw_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  lvw_pkg::cmd_t       head,
    output logic                pop,
    input  lvw_pkg::limit_t     limit_x,
    input  lvw_pkg::limit_t     limit_y,
    input  lvw_pkg::limit_t     limit_z,
    input  logic                res_ready,
    output logic                res_valid,
    output lvw_pkg::res_t       res
);
    import lvw_pkg::*;

    coord_t                       cur_x_reg, cur_y_reg, cur_z_reg;
    coord_t                       cur_x_next, cur_y_next, cur_z_next;
    logic signed [ERR_BITS-1:0]   err_a_reg, err_b_reg;
    logic signed [ERR_BITS-1:0]   err_a_next, err_b_next;
    logic signed [ERR_BITS-1:0]   err_a_load, err_b_load;
    logic [TWICE_BITS-1:0]        tdx_reg, tdy_reg, tdz_reg;
    logic [TWICE_BITS-1:0]        tdx_load, tdy_load, tdz_load;
    logic [TWICE_BITS-1:0]        tw_maj, tw_a, tw_b;
    logic                         neg_x_reg, neg_y_reg, neg_z_reg;
    axis_t                        major_reg;
    axis_t                        major_load;
    mag_t                         steps_left_reg;
    mag_t                         steps_load;
    logic                         active_reg;
    logic                         res_valid_reg;
    res_t                         res_reg;
    res_t                         res_next;
    logic                         step_a, step_b;
    logic                         mv_x, mv_y, mv_z;
    logic                         in_box;
    logic                         is_load, is_step;

    function automatic coord_t inc_of(input logic mv, input logic neg);
        coord_t r;
        r = '0;
        if (mv)
        begin
            r = neg ? '1 : coord_t'(1);
        end
        return r;
    endfunction

    assign is_load = head_valid && (head.op == OP_LOAD);
    assign is_step = head_valid && (head.op == OP_STEP);
    assign pop     = is_load || (is_step && (!res_valid_reg || res_ready));

    // Set-up of a new line: doubled deltas, dominant axis and error terms.
    always_comb
    begin
        tdx_load = {head.mx, 1'b0};
        tdy_load = {head.my, 1'b0};
        tdz_load = {head.mz, 1'b0};
        if (head.mx >= head.my && head.mx >= head.mz)
        begin
            major_load = AXIS_X;
            err_a_load = $signed(ERR_BITS'(tdy_load)) - $signed(ERR_BITS'(head.mx));
            err_b_load = $signed(ERR_BITS'(tdz_load)) - $signed(ERR_BITS'(head.mx));
            steps_load = head.mx;
        end
        else if (head.my >= head.mx && head.my >= head.mz)
        begin
            major_load = AXIS_Y;
            err_a_load = $signed(ERR_BITS'(tdx_load)) - $signed(ERR_BITS'(head.my));
            err_b_load = $signed(ERR_BITS'(tdz_load)) - $signed(ERR_BITS'(head.my));
            steps_load = head.my;
        end
        else
        begin
            major_load = AXIS_Z;
            err_a_load = $signed(ERR_BITS'(tdy_load)) - $signed(ERR_BITS'(head.mz));
            err_b_load = $signed(ERR_BITS'(tdx_load)) - $signed(ERR_BITS'(head.mz));
            steps_load = head.mz;
        end
    end

    // One Bresenham step. Error term a serves y, x, y and b serves z, z, x
    // for dominant axis x, y, z respectively.
    always_comb
    begin
        step_a = !err_a_reg[ERR_BITS-1] && (err_a_reg != '0);
        step_b = !err_b_reg[ERR_BITS-1] && (err_b_reg != '0);
        unique case (major_reg)
            AXIS_X:
            begin
                tw_maj = tdx_reg;
                tw_a   = tdy_reg;
                tw_b   = tdz_reg;
                mv_x   = 1'b1;
                mv_y   = step_a;
                mv_z   = step_b;
            end
            AXIS_Y:
            begin
                tw_maj = tdy_reg;
                tw_a   = tdx_reg;
                tw_b   = tdz_reg;
                mv_x   = step_a;
                mv_y   = 1'b1;
                mv_z   = step_b;
            end
            AXIS_Z:
            begin
                tw_maj = tdz_reg;
                tw_a   = tdy_reg;
                tw_b   = tdx_reg;
                mv_x   = step_b;
                mv_y   = step_a;
                mv_z   = 1'b1;
            end
            default:
            begin
                tw_maj = '0;
                tw_a   = '0;
                tw_b   = '0;
                mv_x   = 1'b0;
                mv_y   = 1'b0;
                mv_z   = 1'b0;
            end
        endcase
        err_a_next = err_a_reg - (step_a ? $signed(ERR_BITS'(tw_maj)) : '0)
                     + $signed(ERR_BITS'(tw_a));
        err_b_next = err_b_reg - (step_b ? $signed(ERR_BITS'(tw_maj)) : '0)
                     + $signed(ERR_BITS'(tw_b));
        cur_x_next = cur_x_reg + inc_of(mv_x, neg_x_reg);
        cur_y_next = cur_y_reg + inc_of(mv_y, neg_y_reg);
        cur_z_next = cur_z_reg + inc_of(mv_z, neg_z_reg);
    end

    assign in_box = (CMP_BITS'(abs_coord(cur_x_reg)) <= CMP_BITS'(limit_x))
                 && (CMP_BITS'(abs_coord(cur_y_reg)) <= CMP_BITS'(limit_y))
                 && (CMP_BITS'(abs_coord(cur_z_reg)) <= CMP_BITS'(limit_z));

    always_comb
    begin
        res_next = '0;
        if (active_reg)
        begin
            res_next.valid_res = 1'b1;
            res_next.x         = cur_x_reg;
            res_next.y         = cur_y_reg;
            res_next.z         = cur_z_reg;
            res_next.in_box    = in_box;
            res_next.last      = (steps_left_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            cur_z_reg      <= '0;
            err_a_reg      <= '0;
            err_b_reg      <= '0;
            tdx_reg        <= '0;
            tdy_reg        <= '0;
            tdz_reg        <= '0;
            neg_x_reg      <= 1'b0;
            neg_y_reg      <= 1'b0;
            neg_z_reg      <= 1'b0;
            major_reg      <= AXIS_X;
            steps_left_reg <= '0;
            active_reg     <= 1'b0;
            res_valid_reg  <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            if (pop && is_step)
            begin
                res_valid_reg <= 1'b1;
                res_reg       <= res_next;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end

            if (pop && is_load)
            begin
                cur_x_reg      <= head.sx;
                cur_y_reg      <= head.sy;
                cur_z_reg      <= head.sz;
                err_a_reg      <= err_a_load;
                err_b_reg      <= err_b_load;
                tdx_reg        <= tdx_load;
                tdy_reg        <= tdy_load;
                tdz_reg        <= tdz_load;
                neg_x_reg      <= head.neg_x;
                neg_y_reg      <= head.neg_y;
                neg_z_reg      <= head.neg_z;
                major_reg      <= major_load;
                steps_left_reg <= steps_load;
                active_reg     <= 1'b1;
            end
            else if (pop && is_step && active_reg)
            begin
                if (steps_left_reg == '0)
                begin
                    active_reg <= 1'b0;
                end
                else
                begin
                    steps_left_reg <= steps_left_reg - 1'b1;
                    err_a_reg      <= err_a_next;
                    err_b_reg      <= err_b_next;
                    cur_x_reg      <= cur_x_next;
                    cur_y_reg      <= cur_y_next;
                    cur_z_reg      <= cur_z_next;
                end
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* hdl/line_voxel_walker_3d.sv */
// Top level of the 3D line voxel walker: configuration registers and block wiring.
module line_voxel_walker_3d (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cmd_valid,
    output logic                                  cmd_ready,
    input  logic                                  opcode,
    input  logic signed [lvw_pkg::COORD_BITS-1:0] start_x,
    input  logic signed [lvw_pkg::COORD_BITS-1:0] start_y,
    input  logic signed [lvw_pkg::COORD_BITS-1:0] start_z,
    input  logic signed [lvw_pkg::COORD_BITS-1:0] end_x,
    input  logic signed [lvw_pkg::COORD_BITS-1:0] end_y,
    input  logic signed [lvw_pkg::COORD_BITS-1:0] end_z,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output logic                                  valid_res,
    output logic signed [lvw_pkg::COORD_BITS-1:0] voxel_x,
    output logic signed [lvw_pkg::COORD_BITS-1:0] voxel_y,
    output logic signed [lvw_pkg::COORD_BITS-1:0] voxel_z,
    output logic                                  inside_res,
    output logic                                  last,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lvw_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [lvw_pkg::LIMIT_BITS-1:0]        cfg_data
);
    // The walker takes one request per clock and returns one voxel per clock,
    // but a step request waits in the queue while the output register holds a
    // voxel that is not being taken. A load request (opcode 0) sets up a new
    // line from two endpoints and returns nothing; each step request (opcode 1)
    // then returns the next voxel, from the start point to the end point
    // inclusive, with the last voxel flagged and a flag telling whether |x|,
    // |y| and |z| all lie within the configured limits. A step request with no
    // line active returns a result whose valid_res bit and every other field
    // are zero. A request is written into the input queue, and a step's voxel
    // is registered in the output register when the walker pops the step; the
    // walker applies a whole Bresenham step (error compare, add and coordinate
    // update) combinationally and registers it on that pop. The front end works
    // out deltas and step signs, and a two-entry queue keeps taking requests
    // until it is full while a voxel waits in the output register.
    // The limit registers (index 0, 1, 2 for x, y, z; reset 680, 170, 170)
    // are written through the configuration channel, which is always ready;
    // writes to any other index are dropped. Write them only while no
    // request is in flight.
    import lvw_pkg::*;

    limit_t  limit_x_reg;
    limit_t  limit_y_reg;
    limit_t  limit_z_reg;
    cmd_t    front_cmd;
    cmd_t    q_head;
    q_stat_t q_stat;
    logic    push;
    logic    pop;
    res_t    res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_x_reg <= LIMIT_X_RESET;
            limit_y_reg <= LIMIT_Y_RESET;
            limit_z_reg <= LIMIT_Z_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_LIMIT_X: limit_x_reg <= cfg_data;
                CFG_LIMIT_Y: limit_y_reg <= cfg_data;
                CFG_LIMIT_Z: limit_z_reg <= cfg_data;
                default:
                begin
                    limit_x_reg <= limit_x_reg;
                end
            endcase
        end
    end

    // Requests are taken whenever the queue has room.
    assign cmd_ready = !q_stat.full;
    assign push      = cmd_valid && cmd_ready;

    lvw_front u_front (
        .opcode  (opcode),
        .start_x (start_x),
        .start_y (start_y),
        .start_z (start_z),
        .end_x   (end_x),
        .end_y   (end_y),
        .end_z   (end_z),
        .cmd     (front_cmd)
    );

    lvw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (front_cmd),
        .pop      (pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    lvw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (!q_stat.empty),
        .head       (q_head),
        .pop        (pop),
        .limit_x    (limit_x_reg),
        .limit_y    (limit_y_reg),
        .limit_z    (limit_z_reg),
        .res_ready  (res_ready),
        .res_valid  (res_valid),
        .res        (res)
    );

    assign valid_res  = res.valid_res;
    assign voxel_x    = res.x;
    assign voxel_y    = res.y;
    assign voxel_z    = res.z;
    assign inside_res = res.in_box;
    assign last       = res.last;

    // The queue can never report full and empty at once.
    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

    // A new result only ever comes from a step request leaving the queue.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(pop && !q_stat.empty && q_head.op == OP_STEP))
        else $error("result appeared without a step request");

    // The last flag is only set on a real voxel.
    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && last) |-> valid_res)
        else $error("last flag set on an invalid result");

    // Nothing is popped from an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from an empty queue");

endmodule

/* sim/tb_line_voxel_walker_3d.sv */
// Self-checking testbench for the 3D line voxel walker: directed lines, then random traffic.
module tb_line_voxel_walker_3d;
    import lvw_pkg::*;

    // Cycles of silence on every channel before the run is declared hung.
    localparam int QUIET_LIMIT = 1000;
    // Settling time after the last result before a register write, and at the end.
    localparam int SETTLE_CYCLES = 20;
    // The register index that the block must ignore.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;
    // Random requests per phase of the random part.
    localparam int PHASE_REQUESTS = 245;

    logic clk = 1'b0;
    logic rst_n;

    logic    cmd_valid;
    logic    cmd_ready;
    opcode_t req_op;
    coord_t  req_sx, req_sy, req_sz, req_ex, req_ey, req_ez;

    logic    res_valid;
    logic    res_ready;
    logic    valid_res;
    coord_t  voxel_x, voxel_y, voxel_z;
    logic    inside_res;
    logic    last;

    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    limit_t                  cfg_data;

    // Voxels that the walker model expects, oldest first.
    res_t expected_voxels[$];

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int send_burst     = 0;
    int sink_burst     = 0;

    // Our own copy of the walker: box limits and the line being walked.
    limit_t box_x = LIMIT_X_RESET;
    limit_t box_y = LIMIT_Y_RESET;
    limit_t box_z = LIMIT_Z_RESET;
    int     walk_x = 0, walk_y = 0, walk_z = 0;
    int     err_a = 0, err_b = 0;
    int     twice_dx = 0, twice_dy = 0, twice_dz = 0;
    logic [2:0] walk_neg = 3'b000;
    axis_t  walk_major = AXIS_X;
    int     voxels_left = 0;
    bit     line_live = 1'b0;

    line_voxel_walker_3d i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .opcode     (req_op),
        .start_x    (req_sx),
        .start_y    (req_sy),
        .start_z    (req_sz),
        .end_x      (req_ex),
        .end_y      (req_ey),
        .end_z      (req_ez),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .valid_res  (valid_res),
        .voxel_x    (voxel_x),
        .voxel_y    (voxel_y),
        .voxel_z    (voxel_z),
        .inside_res (inside_res),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Pause drawn for every request on either side. Now and then a burst of
    // back-to-back requests is started, so that both stalled and flat-out
    // stretches are seen.
    function automatic int draw_pause(inout int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
            burst = $urandom_range(20, 80);
        return $urandom_range(0, 17);
    endfunction

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int axis_dir(input logic neg);
        return neg ? -1 : 1;
    endfunction

    // Saturates a computed endpoint into the coordinate range.
    function automatic coord_t clip_coord(input int v);
        if (v > 32767)
            return coord_t'(32767);
        if (v < -32768)
            return coord_t'(-32768);
        return coord_t'(v);
    endfunction

    // A start coordinate: either anywhere, or close to the box face on either
    // side, so that the inside flag flips along the line.
    function automatic coord_t pick_coord(input limit_t face);
        int v;
        if ($urandom_range(0, 2) != 0)
            return coord_t'($urandom);
        v = int'(face) + $urandom_range(0, 6) - 3;
        return clip_coord(($urandom_range(0, 1) != 0) ? -v : v);
    endfunction

    // A load works out the doubled deltas, the dominant axis and the two
    // error terms; it yields no voxel.
    task automatic walk_load(input coord_t sx, sy, sz, ex, ey, ez);
        int dx, dy, dz, ax, ay, az;
        dx = int'(ex) - int'(sx);
        dy = int'(ey) - int'(sy);
        dz = int'(ez) - int'(sz);
        ax = magnitude(dx);
        ay = magnitude(dy);
        az = magnitude(dz);
        walk_x   = int'(sx);
        walk_y   = int'(sy);
        walk_z   = int'(sz);
        walk_neg = {dz < 0, dy < 0, dx < 0};
        twice_dx = 2 * ax;
        twice_dy = 2 * ay;
        twice_dz = 2 * az;
        if (ax >= ay && ax >= az)
        begin
            walk_major  = AXIS_X;
            err_a       = twice_dy - ax;
            err_b       = twice_dz - ax;
            voxels_left = ax;
        end
        else if (ay >= ax && ay >= az)
        begin
            walk_major  = AXIS_Y;
            err_a       = twice_dx - ay;
            err_b       = twice_dz - ay;
            voxels_left = ay;
        end
        else
        begin
            // With z dominant the first error term serves y and the second x.
            walk_major  = AXIS_Z;
            err_a       = twice_dy - az;
            err_b       = twice_dx - az;
            voxels_left = az;
        end
        line_live = 1'b1;
    endtask

    // A step yields the current voxel and then advances along the line.
    task automatic walk_step();
        res_t v;
        v = '0;
        if (line_live)
        begin
            v.valid_res = 1'b1;
            v.x = coord_t'(walk_x);
            v.y = coord_t'(walk_y);
            v.z = coord_t'(walk_z);
            v.in_box = magnitude(walk_x) <= int'(box_x) && magnitude(walk_y) <= int'(box_y)
                       && magnitude(walk_z) <= int'(box_z);
            if (voxels_left == 0)
            begin
                v.last    = 1'b1;
                line_live = 1'b0;
            end
            else
            begin
                voxels_left--;
                case (walk_major)
                    AXIS_X:
                    begin
                        if (err_a > 0)
                        begin
                            walk_y += axis_dir(walk_neg[1]);
                            err_a  -= twice_dx;
                        end
                        if (err_b > 0)
                        begin
                            walk_z += axis_dir(walk_neg[2]);
                            err_b  -= twice_dx;
                        end
                        err_a  += twice_dy;
                        err_b  += twice_dz;
                        walk_x += axis_dir(walk_neg[0]);
                    end
                    AXIS_Y:
                    begin
                        if (err_a > 0)
                        begin
                            walk_x += axis_dir(walk_neg[0]);
                            err_a  -= twice_dy;
                        end
                        if (err_b > 0)
                        begin
                            walk_z += axis_dir(walk_neg[2]);
                            err_b  -= twice_dy;
                        end
                        err_a  += twice_dx;
                        err_b  += twice_dz;
                        walk_y += axis_dir(walk_neg[1]);
                    end
                    default:
                    begin
                        if (err_a > 0)
                        begin
                            walk_y += axis_dir(walk_neg[1]);
                            err_a  -= twice_dz;
                        end
                        if (err_b > 0)
                        begin
                            walk_x += axis_dir(walk_neg[0]);
                            err_b  -= twice_dz;
                        end
                        err_a  += twice_dy;
                        err_b  += twice_dx;
                        walk_z += axis_dir(walk_neg[2]);
                    end
                endcase
            end
        end
        // A step with no line live still yields a voxel, flagged invalid and all zero.
        expected_voxels.push_back(v);
    endtask

    task automatic report_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Everything is observed on the rising edge. A request accepted on an edge
    // is predicted before any voxel of the same edge is checked, so the model
    // is right even if the block answered in the same cycle.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready)
            begin
                if (req_op == OP_LOAD)
                    walk_load(req_sx, req_sy, req_sz, req_ex, req_ey, req_ez);
                else
                    walk_step();
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LIMIT_X: box_x = cfg_data;
                    CFG_LIMIT_Y: box_y = cfg_data;
                    CFG_LIMIT_Z: box_z = cfg_data;
                    default: ;
                endcase
            end
            if (res_valid && res_ready)
            begin
                if (expected_voxels.size() == 0)
                begin
                    $display("%0t: unexpected voxel, expected none, actual valid %0b (%0d,%0d,%0d)",
                             $time, valid_res, voxel_x, voxel_y, voxel_z);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_voxels.pop_front();
                    report_field("valid_res", want.valid_res, valid_res);
                    report_field("voxel_x", want.x, voxel_x);
                    report_field("voxel_y", want.y, voxel_y);
                    report_field("voxel_z", want.z, voxel_z);
                    report_field("inside_res", want.in_box, inside_res);
                    report_field("last", want.last, last);
                end
            end
        end
        if ((cmd_valid && cmd_ready) || (cfg_valid && cfg_ready) || (res_valid && res_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    // Watchdog: ends the run if no channel moves for too long.
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    // Result side: holds ready low for a drawn number of cycles before each voxel.
    initial
    begin : result_sink
        int stall;
        forever
        begin
            stall = draw_pause(sink_burst);
            @(negedge clk);
            if (stall > 0)
            begin
                res_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ready <= 1'b1;
            @(posedge clk);
            while (!(res_valid && res_ready))
                @(posedge clk);
        end
    end

    // Sends one request. Valid is left high after acceptance; the next call
    // either holds it high with a new payload or drops it for the drawn gap.
    task automatic send_request(input opcode_t op, input coord_t sx, sy, sz, ex, ey, ez);
        int gap;
        gap = draw_pause(send_burst);
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        req_op    <= op;
        req_sx    <= sx;
        req_sy    <= sy;
        req_sz    <= sz;
        req_ex    <= ex;
        req_ey    <= ey;
        req_ez    <= ez;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
    endtask

    // Step requests carry random endpoints, which the block must ignore.
    task automatic send_step();
        send_request(OP_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                     coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
    endtask

    // Brings the block to rest: no request pending, every voxel delivered, and
    // time for a load still being digested to finish.
    task automatic wait_idle();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (expected_voxels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx, input limit_t value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_box(input limit_t lx, ly, lz);
        wait_idle();
        write_register(CFG_LIMIT_X, lx);
        write_register(CFG_LIMIT_Y, ly);
        write_register(CFG_LIMIT_Z, lz);
    endtask

    // Random traffic. Most requests form whole lines with random content; some
    // lines are abandoned part-way by a new load, and a few loads are full-range
    // noise followed by a handful of steps. Extra steps after the last voxel
    // exercise stepping with no line live.
    task automatic random_lines(input int goal);
        int     sent, kind, span, len, steps, k;
        coord_t sx, sy, sz, ex, ey, ez;
        sent = 0;
        while (sent < goal)
        begin
            kind = $urandom_range(0, 99);
            span = ($urandom_range(0, 9) == 0) ? 60 : 12;
            sx = pick_coord(box_x);
            sy = pick_coord(box_y);
            sz = pick_coord(box_z);
            ex = clip_coord(int'(sx) + $urandom_range(0, 2 * span) - span);
            ey = clip_coord(int'(sy) + $urandom_range(0, 2 * span) - span);
            ez = clip_coord(int'(sz) + $urandom_range(0, 2 * span) - span);
            if (kind >= 90)
            begin
                ex = coord_t'($urandom);
                ey = coord_t'($urandom);
                ez = coord_t'($urandom);
            end
            len = magnitude(int'(ex) - int'(sx));
            if (magnitude(int'(ey) - int'(sy)) > len)
                len = magnitude(int'(ey) - int'(sy));
            if (magnitude(int'(ez) - int'(sz)) > len)
                len = magnitude(int'(ez) - int'(sz));
            send_request(OP_LOAD, sx, sy, sz, ex, ey, ez);
            sent++;
            if (kind < 75)
                steps = len + 1 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
            else if (kind < 90)
                steps = $urandom_range(0, len);
            else
                steps = $urandom_range(0, 3);
            for (k = 0; k < steps; k++)
            begin
                send_step();
                sent++;
            end
        end
    endtask

    task automatic test_step_while_idle();
        send_step();
    endtask

    // Equal endpoints give one voxel marked last; the step after it finds no line.
    task automatic test_single_point_line();
        send_request(OP_LOAD, 16'sd32767, -16'sd32768, 16'sd0, 16'sd32767, -16'sd32768, 16'sd0);
        send_step();
        send_step();
    endtask

    // Corner to corner both ways; the second load replaces a line still live.
    task automatic test_extreme_endpoints();
        coord_t lo, hi;
        lo = coord_t'(-32768);
        hi = coord_t'(32767);
        send_request(OP_LOAD, lo, lo, lo, hi, hi, hi);
        send_step();
        send_step();
        send_request(OP_LOAD, hi, hi, hi, lo, lo, lo);
        send_step();
        send_step();
    endtask

    // y dominant with mixed signs, an x/y tie that must go to x, and z dominant.
    task automatic test_major_axis_selection();
        int k;
        send_request(OP_LOAD, 16'sd0, 16'sd0, 16'sd0, 16'sd2, -16'sd5, 16'sd3);
        for (k = 0; k < 6; k++)
            send_step();
        send_request(OP_LOAD, -16'sd3, 16'sd4, 16'sd0, 16'sd0, 16'sd7, 16'sd1);
        for (k = 0; k < 4; k++)
            send_step();
        send_request(OP_LOAD, 16'sd5, 16'sd5, 16'sd5, 16'sd4, 16'sd6, 16'sd2);
        for (k = 0; k < 4; k++)
            send_step();
    endtask

    task automatic test_walk_default_limits();
        random_lines(PHASE_REQUESTS);
    endtask

    // An empty box, where only the origin is inside, then the widest box.
    task automatic test_walk_limit_extremes();
        write_box('0, '0, '0);
        random_lines(PHASE_REQUESTS);
        write_box('1, '1, '1);
        random_lines(PHASE_REQUESTS);
    endtask

    // A write to the spare index must leave all three limits alone.
    task automatic test_unknown_register();
        write_box(limit_t'($urandom_range(0, 400)), limit_t'($urandom_range(0, 400)),
                  limit_t'($urandom_range(0, 400)));
        write_register(CFG_SPARE, limit_t'($urandom));
        random_lines(PHASE_REQUESTS);
    endtask

    task automatic test_walk_random_limits();
        write_box(limit_t'($urandom), limit_t'($urandom_range(0, 60)),
                  limit_t'($urandom_range(0, 2000)));
        random_lines(PHASE_REQUESTS);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        req_op    = OP_LOAD;
        req_sx    = '0;
        req_sy    = '0;
        req_sz    = '0;
        req_ex    = '0;
        req_ey    = '0;
        req_ez    = '0;
        res_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_LIMIT_X;
        cfg_data  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_step_while_idle();
        test_single_point_line();
        test_extreme_endpoints();
        test_major_axis_selection();
        test_walk_default_limits();
        test_walk_limit_extremes();
        test_unknown_register();
        test_walk_random_limits();

        // Drain: the watchdog bounds this wait if voxels go missing.
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (expected_voxels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
